// ----- hdl/vag_adpcm_pkg.sv -----
package vag_adpcm_pkg;

  // Highest channel count that the predictor history is built for.
  localparam int MAX_CHANNELS = 2;

  // Largest legal block shift and filter index.
  localparam logic [3:0] SHIFT_MAX = 4'd12;
  localparam logic [3:0] FILTER_MAX = 4'd4;

  // Largest chunk length in blocks.
  localparam logic [12:0] INTERLEAVE_MAX = 13'd4096;

  // Rounding bias added before the predictor is scaled down by 64.
  localparam logic signed [24:0] PRED_ROUND = 25'sd32;

  // Status codes carried by every result.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHIFT  = 3'd1,
    ST_FILTER = 3'd2,
    ST_TRUNC  = 3'd3,
    ST_CHUNK  = 3'd4
  } status_t;

  // Register word indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_CHANNELS   = 2'd0,
    REG_INTERLEAVE = 2'd1,
    REG_STRICT     = 2'd2
  } reg_idx_t;

  // First predictor tap, applied to the previous sample.
  function automatic logic signed [7:0] tap_a(input logic [2:0] filter);
    case (filter)
      3'd1:    return 8'sd60;
      3'd2:    return 8'sd115;
      3'd3:    return 8'sd98;
      3'd4:    return 8'sd122;
      default: return 8'sd0;
    endcase
  endfunction

  // Second predictor tap, applied to the sample before the previous one.
  function automatic logic signed [7:0] tap_b(input logic [2:0] filter);
    case (filter)
      3'd2:    return -8'sd52;
      3'd3:    return -8'sd55;
      3'd4:    return -8'sd60;
      default: return 8'sd0;
    endcase
  endfunction

endpackage

// ----- hdl/vag_adpcm_block_decoder.sv -----
// Streaming decoder for 4-bit ADPCM in 16-byte blocks, one compressed byte per
// request on the input channel. Header bytes and the skipped second byte of a
// block give no result; each data byte gives two samples in turn, low nibble
// first, because the second sample's predictor needs the first sample, and
// both share one predictor unit (two small multipliers, a rounding add and a
// saturating add). Bad headers, a truncated block or a missing channel chunk
// at end of stream give a single error result with a zero sample and status
// code, after which bytes are dropped until end of stream. End of stream
// clears all decode state. Results leave through a one-entry output register
// that refills in the cycle it drains, so bytes flow without gaps while the
// result channel keeps up; a stalled result holds back only a byte that has
// to load the next result, and bytes that give no result pass on.
// The user must write configuration through the APB port only while the block
// is idle; the block itself does not enforce this.
module vag_adpcm_block_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_stream,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_channel,
  output logic [2:0]         out_status,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import vag_adpcm_pkg::*;

  // Configuration registers.
  logic [1:0]  chans_r;
  logic [12:0] ilv_r;
  logic        strict_r;

  // Input register and the phase of a data byte (0 low nibble, 1 high nibble).
  logic        hv_r;
  logic [7:0]  byte_r;
  logic        eos_r;
  logic        phase_r, phase_nxt;

  // Decode state.
  logic [3:0]  bib_r, bib_nxt;
  logic [11:0] bic_r, bic_nxt;
  logic        cur_r, cur_nxt;
  logic [3:0]  shift_r, shift_nxt;
  logic [2:0]  filt_r, filt_nxt;
  logic        err_r, err_nxt;
  logic        dch_r, dch_nxt;
  logic        och_r, och_nxt;
  logic signed [15:0] p1_r [2];
  logic signed [15:0] p2_r [2];
  logic signed [15:0] p1_nxt [2];
  logic signed [15:0] p2_nxt [2];

  // Output register.
  logic               ov_r;
  logic signed [15:0] osample_r, osample_nxt;
  logic               ochan_r, ochan_nxt;
  status_t            ostatus_r, ostatus_nxt;
  logic               olast_r, olast_nxt;

  // Configuration write and read.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r  <= 2'd1;
      ilv_r    <= 13'd128;
      strict_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CHANNELS:   chans_r  <= pwdata[1:0];
        REG_INTERLEAVE: ilv_r    <= pwdata[12:0];
        REG_STRICT:     strict_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNELS:   prdata = {30'd0, chans_r};
      REG_INTERLEAVE: prdata = {19'd0, ilv_r};
      REG_STRICT:     prdata = {31'd0, strict_r};
      default:        prdata = 32'd0;
    endcase
  end

  // Effective channel count and chunk length after clamping odd values.
  logic        stereo;
  logic [12:0] ilv_eff;
  assign stereo = chans_r[1] && (MAX_CHANNELS >= 2);
  always_comb begin
    if (ilv_r == 13'd0) begin
      ilv_eff = 13'd1;
    end else if (ilv_r > INTERLEAVE_MAX) begin
      ilv_eff = INTERLEAVE_MAX;
    end else begin
      ilv_eff = ilv_r;
    end
  end

  // Shared predictor unit: one sample per cycle from history unless stalled.
  logic               su_ch;
  logic [3:0]         su_nib;
  logic signed [15:0] su_code;
  logic signed [23:0] su_pa, su_pb;
  logic signed [24:0] su_sum;
  logic signed [18:0] su_pred;
  logic signed [19:0] su_wide;
  logic signed [15:0] su_val;

  assign su_ch   = phase_r ? dch_r : cur_r;
  assign su_nib  = phase_r ? byte_r[7:4] : byte_r[3:0];
  assign su_code = $signed({su_nib, 12'd0}) >>> shift_r;
  assign su_pa   = 24'(p1_r[su_ch]) * 24'(tap_a(filt_r));
  assign su_pb   = 24'(p2_r[su_ch]) * 24'(tap_b(filt_r));
  assign su_sum  = 25'(su_pa) + 25'(su_pb) + PRED_ROUND;
  assign su_pred = $signed(su_sum[24:6]);
  assign su_wide = 20'(su_code) + 20'(su_pred);

  always_comb begin
    if (su_wide > 20'sd32767) begin
      su_val = 16'sh7fff;
    end else if (su_wide < -20'sd32768) begin
      su_val = -16'sh8000;
    end else begin
      su_val = su_wide[15:0];
    end
  end

  // Block and chunk bookkeeping for the byte in the input register.
  logic        is_hdr, is_data, last_b, wrap;
  logic        sh_err, fl_err, hdr_err, trunc_err, chunk_err, samples;
  logic [3:0]  nbib;
  logic [11:0] nbic;
  logic        nch, ochs;
  logic        res_v, out_free, go, fin, do_clear;

  always_comb begin
    is_hdr  = (bib_r == 4'd0);
    is_data = (bib_r > 4'd1);
    last_b  = (bib_r == 4'd15);
    wrap    = ({1'b0, bic_r} + 13'd1) >= ilv_eff;
    sh_err  = is_hdr && (byte_r[3:0] > SHIFT_MAX);
    fl_err  = is_hdr && !sh_err && (byte_r[7:4] > FILTER_MAX) && strict_r;
    hdr_err = sh_err || fl_err;

    nbib = bib_r + 4'd1;
    nbic = bic_r;
    nch  = cur_r;
    if (last_b) begin
      if (wrap) begin
        nbic = 12'd0;
        nch  = stereo ? ~cur_r : 1'b0;
      end else begin
        nbic = bic_r + 12'd1;
      end
    end

    trunc_err = eos_r && (nbib != 4'd0);
    chunk_err = eos_r && !trunc_err && stereo &&
                (nch ? (nbic == 12'd0) : (nbic != 12'd0));
    samples   = !err_r && !hdr_err && is_data && !trunc_err && !chunk_err;
    ochs      = nch ^ (last_b && (nbic == 12'd0) && stereo);

    res_v    = phase_r || (!err_r && (hdr_err || trunc_err || chunk_err || samples));
    out_free = !ov_r || !out_stall;
    go       = hv_r && (!res_v || out_free);
    fin      = go && (phase_r || !samples);
  end

  // Input handshake: the register frees when its byte is fully handled.
  assign in_stall = !rst_n || (hv_r && !fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hv_r <= 1'b1;
    end else if (fin) begin
      hv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_data_byte;
      eos_r  <= in_end_of_stream;
    end
  end

  // Next decode state and the result to load.
  always_comb begin
    phase_nxt   = phase_r;
    bib_nxt     = bib_r;
    bic_nxt     = bic_r;
    cur_nxt     = cur_r;
    shift_nxt   = shift_r;
    filt_nxt    = filt_r;
    err_nxt     = err_r;
    dch_nxt     = dch_r;
    och_nxt     = och_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    do_clear    = 1'b0;
    osample_nxt = 16'sd0;
    ochan_nxt   = cur_r;
    ostatus_nxt = ST_OK;
    olast_nxt   = 1'b1;

    if (go) begin
      if (phase_r) begin
        // Second sample of a data byte.
        phase_nxt         = 1'b0;
        p2_nxt[dch_r]     = p1_r[dch_r];
        p1_nxt[dch_r]     = su_val;
        osample_nxt       = su_val;
        ochan_nxt         = och_r;
        do_clear          = eos_r;
      end else if (err_r) begin
        // Bytes after an error are dropped until end of stream.
        do_clear = eos_r;
      end else if (hdr_err) begin
        err_nxt = 1'b1;
        if (sh_err) begin
          ostatus_nxt = ST_SHIFT;
        end else begin
          ostatus_nxt = ST_FILTER;
        end
        do_clear = eos_r;
      end else begin
        bib_nxt = nbib;
        bic_nxt = nbic;
        cur_nxt = nch;
        if (is_hdr) begin
          shift_nxt = byte_r[3:0];
          filt_nxt  = (byte_r[7:4] > FILTER_MAX) ? 3'd4 : byte_r[6:4];
        end
        if (samples) begin
          phase_nxt     = 1'b1;
          dch_nxt       = cur_r;
          och_nxt       = ochs;
          p2_nxt[cur_r] = p1_r[cur_r];
          p1_nxt[cur_r] = su_val;
          osample_nxt   = su_val;
          ochan_nxt     = ochs;
          olast_nxt     = 1'b0;
        end else begin
          ochan_nxt = nch;
          if (trunc_err) begin
            ostatus_nxt = ST_TRUNC;
          end else begin
            ostatus_nxt = ST_CHUNK;
          end
          err_nxt  = trunc_err || chunk_err;
          do_clear = eos_r;
        end
      end
    end

    // End of stream wipes all decode state.
    if (do_clear) begin
      bib_nxt   = 4'd0;
      bic_nxt   = 12'd0;
      cur_nxt   = 1'b0;
      shift_nxt = 4'd0;
      filt_nxt  = 3'd0;
      err_nxt   = 1'b0;
      p1_nxt    = '{default: 16'sd0};
      p2_nxt    = '{default: 16'sd0};
    end
  end

  // Decode state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      bib_r   <= 4'd0;
      bic_r   <= 12'd0;
      cur_r   <= 1'b0;
      shift_r <= 4'd0;
      filt_r  <= 3'd0;
      err_r   <= 1'b0;
      p1_r    <= '{default: 16'sd0};
      p2_r    <= '{default: 16'sd0};
    end else begin
      phase_r <= phase_nxt;
      bib_r   <= bib_nxt;
      bic_r   <= bic_nxt;
      cur_r   <= cur_nxt;
      shift_r <= shift_nxt;
      filt_r  <= filt_nxt;
      err_r   <= err_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dch_r <= dch_nxt;
    och_r <= och_nxt;
  end

  // Output register: loads a result, else drains when the request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (go && res_v) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_v) begin
      osample_r <= osample_nxt;
      ochan_r   <= ochan_nxt;
      ostatus_r <= ostatus_nxt;
      olast_r   <= olast_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign out_sample  = osample_r;
  assign out_channel = ochan_r;
  assign out_status  = ostatus_r;
  assign out_last    = olast_r;

endmodule

// ----- hdl/vag_adpcm_chk.sv -----
module vag_adpcm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sample,
  input logic               out_channel,
  input logic [2:0]         out_status,
  input logic               out_last
);
  import vag_adpcm_pkg::*;

  // A stalled result request holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("result changed while stalled");

  // An error result carries a zero sample and closes its byte.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_sample == 16'sd0) && out_last)
    else $error("error result with sample or without last");

  // The first sample of a byte is followed at once by its second sample.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && out_last && (out_status == ST_OK) &&
      (out_channel == $past(out_channel)))
    else $error("second sample of a byte missing or on another channel");

endmodule

bind vag_adpcm_block_decoder vag_adpcm_chk u_vag_adpcm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_sample  (out_sample),
  .out_channel (out_channel),
  .out_status  (out_status),
  .out_last    (out_last)
);
